>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Assertion sampled on clk, held off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion sampled on clk that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/sha1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sha1_pkg
// Transfer types and SHA-1 constants for the byte stream hasher.
// ---------------------------------------------------------------------------
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  // Initial chaining values
  localparam logic [31:0] H_INIT0 = 32'h6745_2301;
  localparam logic [31:0] H_INIT1 = 32'hEFCD_AB89;
  localparam logic [31:0] H_INIT2 = 32'h98BA_DCFE;
  localparam logic [31:0] H_INIT3 = 32'h1032_5476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2_E1F0;

  // Round constants
  localparam logic [31:0] K_R0 = 32'h5A82_7999;
  localparam logic [31:0] K_R1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_R3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;   // length field starts here
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [3:0] LEN_BYTES  = 4'd8;
  localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage : sha1_pkg
`default_nettype wire

>>> hdl/sha1_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sha1_byte_stream_hasher_core
// SHA-1 over a byte stream: block buffering, padding, 80-round compression.
// ---------------------------------------------------------------------------
//
//  channel | ports                         | moves per transfer
//  --------+-------------------------------+----------------------------------
//  in      | in_valid, in_stall, in_data   | one message byte + last flag
//  out     | out_valid, out_stall, out_data| one digest word, index, last flag
//
//  A byte is taken while the sequencer is idle. Each 64th byte starts
//  the rounds on the shared round adder, then the ADD state folds the
//  result into the chaining words; in_stall holds new bytes meanwhile.
//  The last byte adds one pad byte per cycle (up to 72, with one more block
//  compression if the length field spills over), then five out transfers.
//  rst_n is synchronous; it loads the initial chaining values and clears
//  the sequencer. An out stall holds the current digest word in place.
//
module sha1_byte_stream_hasher_core
  import sha1_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire sha1_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output sha1_out_t      out_data
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message bytes
  localparam logic [2:0] ST_PAD   = 3'd1;  // one pad byte per cycle
  localparam logic [2:0] ST_ROUND = 3'd2;  // one round per cycle
  localparam logic [2:0] ST_ADD   = 3'd3;  // fold work vars into hash
  localparam logic [2:0] ST_OUT   = 3'd4;  // digest word transfers

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  pos_r, pos_nxt;            // byte position in block
  logic [63:0] bit_cnt_r, bit_cnt_nxt;    // bit count, shifts out as length
  logic [6:0]  rnd_r, rnd_nxt;
  logic [3:0]  len_cnt_r, len_cnt_nxt;    // length bytes absorbed
  logic        fin_r, fin_nxt;            // message end seen
  logic        mark_r, mark_nxt;          // 0x80 pad byte still pending
  logic [2:0]  out_idx_r, out_idx_nxt;

  logic [31:0] h_r   [5];
  logic [31:0] h_nxt [5];
  logic [31:0] blk_r   [16];              // byte shift line / schedule window
  logic [31:0] blk_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic        byte_en;
  logic [7:0]  byte_val;
  logic        start_comp;
  logic [31:0] f_val, k_val, w_new, tmp_sum;

  // Round function and constant by round group
  always_comb begin
    case (rnd_r) inside
      [7'd0:7'd19]: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K_R0;
      end
      [7'd20:7'd39]: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_R1;
      end
      [7'd40:7'd59]: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K_R2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K_R3;
      end
    endcase
  end

  // Shared round unit: rotl5(a) + f + e + k + W[t]
  assign tmp_sum = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + blk_r[0];

  // Next schedule word, W[t+16]
  always_comb begin
    logic [31:0] x;
    x     = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
    w_new = {x[30:0], x[31]};
  end

  always_comb begin
    st_nxt      = st_r;
    pos_nxt     = pos_r;
    bit_cnt_nxt = bit_cnt_r;
    rnd_nxt     = rnd_r;
    len_cnt_nxt = len_cnt_r;
    fin_nxt     = fin_r;
    mark_nxt    = mark_r;
    out_idx_nxt = out_idx_r;
    h_nxt       = h_r;
    blk_nxt     = blk_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    e_nxt       = e_r;
    byte_en     = 1'b0;
    byte_val    = 8'h00;
    start_comp  = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_en     = 1'b1;
          byte_val    = in_data.data_byte;
          bit_cnt_nxt = bit_cnt_r + 64'd8;
          if (in_data.last_byte) begin
            fin_nxt  = 1'b1;
            mark_nxt = 1'b1;
          end
          if (pos_r == 6'd63) begin
            start_comp = 1'b1;
          end else if (in_data.last_byte) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_en = 1'b1;
        if (mark_r) begin
          byte_val = PAD_MARK;
          mark_nxt = 1'b0;
        end else if (len_cnt_r == 4'd0 && pos_r != LEN_POS) begin
          byte_val = 8'h00;
        end else begin
          // length goes out big-endian, top byte first
          byte_val    = bit_cnt_r[63:56];
          bit_cnt_nxt = {bit_cnt_r[55:0], 8'h00};
          len_cnt_nxt = len_cnt_r + 4'd1;
        end
        if (pos_r == 6'd63) begin
          start_comp = 1'b1;
        end
      end
      ST_ROUND: begin
        e_nxt = d_r;
        d_nxt = c_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        b_nxt = a_r;
        a_nxt = tmp_sum;
        for (int i = 0; i < 15; i++) begin
          blk_nxt[i] = blk_r[i+1];
        end
        blk_nxt[15] = w_new;
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt = 7'd0;
          st_nxt  = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (fin_r && len_cnt_r == LEN_BYTES) begin
          st_nxt = ST_OUT;
        end else if (fin_r) begin
          st_nxt = ST_PAD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          // rotate so the next word sits at the front
          for (int i = 0; i < 4; i++) begin
            h_nxt[i] = h_r[i+1];
          end
          h_nxt[4]    = h_r[0];
          out_idx_nxt = out_idx_r + 3'd1;
          if (out_idx_r == LAST_WORD) begin
            // back to a fresh message; pos and bit count are already zero
            h_nxt[0]    = H_INIT0;
            h_nxt[1]    = H_INIT1;
            h_nxt[2]    = H_INIT2;
            h_nxt[3]    = H_INIT3;
            h_nxt[4]    = H_INIT4;
            out_idx_nxt = 3'd0;
            len_cnt_nxt = 4'd0;
            fin_nxt     = 1'b0;
            st_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Bytes enter at the bottom; the first byte ends in the top of word 0
    if (byte_en) begin
      for (int i = 0; i < 15; i++) begin
        blk_nxt[i] = {blk_r[i][23:0], blk_r[i+1][31:24]};
      end
      blk_nxt[15] = {blk_r[15][23:0], byte_val};
      pos_nxt     = pos_r + 6'd1;
    end

    if (start_comp) begin
      st_nxt  = ST_ROUND;
      rnd_nxt = 7'd0;
      a_nxt   = h_r[0];
      b_nxt   = h_r[1];
      c_nxt   = h_r[2];
      d_nxt   = h_r[3];
      e_nxt   = h_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      pos_r     <= 6'd0;
      bit_cnt_r <= 64'd0;
      rnd_r     <= 7'd0;
      len_cnt_r <= 4'd0;
      fin_r     <= 1'b0;
      mark_r    <= 1'b0;
      out_idx_r <= 3'd0;
      h_r[0]    <= H_INIT0;
      h_r[1]    <= H_INIT1;
      h_r[2]    <= H_INIT2;
      h_r[3]    <= H_INIT3;
      h_r[4]    <= H_INIT4;
    end else begin
      st_r      <= st_nxt;
      pos_r     <= pos_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      rnd_r     <= rnd_nxt;
      len_cnt_r <= len_cnt_nxt;
      fin_r     <= fin_nxt;
      mark_r    <= mark_nxt;
      out_idx_r <= out_idx_nxt;
      h_r       <= h_nxt;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  assign in_stall             = (st_r != ST_IDLE);
  assign out_valid            = (st_r == ST_OUT);
  assign out_data.digest_word = h_r[0];
  assign out_data.word_index  = out_idx_r;
  assign out_data.last_word   = (out_idx_r == LAST_WORD);

`include "assert_macros.svh"

  `ASSERT_CLK(a_out_blocks_in, out_valid |-> in_stall, "digest out while taking bytes")
  `ASSERT_CLK(a_round_range, (st_r == ST_ROUND) |-> (rnd_r <= LAST_ROUND), "round past 79")
  `ASSERT_CLK(a_fresh_after_digest, (out_valid && !out_stall && out_data.last_word) |=> (st_r == ST_IDLE && bit_cnt_r == 64'd0 && pos_r == 6'd0), "state not fresh after digest")
  `ASSERT_CLK(a_len_done_state, (len_cnt_r == LEN_BYTES) |-> (st_r == ST_ROUND || st_r == ST_ADD || st_r == ST_OUT), "length absorbed outside final block")
  `ASSERT_CLK(a_out_at_block_edge, out_valid |-> (pos_r == 6'd0 && fin_r), "digest out mid block")

endmodule : sha1_byte_stream_hasher_core
`default_nettype wire

>>> tb/sha1_byte_stream_hasher_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_byte_stream_hasher_core_test
// Streams byte messages into the hasher and checks every digest word against
// a SHA-1 predictor run on each accepted byte, with random gaps and stalls.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hasher_core_test;
  import sha1_pkg::*;

  localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side

  typedef struct {
    sha1_in_t item;
    bit       drain_first;  // hold this byte until all digests are out
  } queued_byte_t;

  // content styles for generated messages
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_ALT} fill_style_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sha1_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sha1_out_t out_data;

  sha1_byte_stream_hasher_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor state: chaining words, block buffer, bit length, fill position
  // -------------------------------------------------------------------------
  logic [31:0] hash_chain [5];
  logic [31:0] block_buf [16];
  logic [63:0] msg_bit_len;
  logic [5:0]  block_fill;

  queued_byte_t byte_queue[$];     // bytes waiting to be sent
  sha1_out_t    digest_queue[$];   // digest words still owed by the block

  int error_count = 0;
  int in_idle_left = 0;
  int out_idle_left = 0;
  int in_calm = 0;
  int out_calm = 0;
  int quiet_cycles = 0;

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Wait length for one transfer: a uniform random draw, with runs of no waiting at all.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic hash_reset();
    hash_chain[0] = H_INIT0;
    hash_chain[1] = H_INIT1;
    hash_chain[2] = H_INIT2;
    hash_chain[3] = H_INIT3;
    hash_chain[4] = H_INIT4;
    foreach (block_buf[i]) block_buf[i] = '0;
    msg_bit_len = '0;
    block_fill = '0;
  endtask

  // 80 rounds over the buffered block, folded into the chaining words
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, sum;
    w = block_buf;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t % 16] = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      sum = rotl(a, 5) + f + e + k + w[t % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endtask

  // big-endian packing; first byte of a word clears the rest of it
  task automatic pack_byte(logic [7:0] value);
    if (block_fill[1:0] == 2'd0)
      block_buf[block_fill[5:2]] = {value, 24'h0};
    else
      block_buf[block_fill[5:2]][8 * (3 - block_fill[1:0]) +: 8] = value;
    block_fill++;
    if (block_fill == 6'd0)
      compress_block();
  endtask

  // One accepted byte; on the final byte pad, finish and queue five words.
  task automatic hash_take_byte(sha1_in_t it);
    logic [63:0] len;
    sha1_out_t word;
    pack_byte(it.data_byte);
    msg_bit_len += 64'd8;
    if (it.last_byte) begin
      len = msg_bit_len;
      pack_byte(PAD_MARK);
      while (block_fill != LEN_POS)
        pack_byte(8'h00);
      for (int i = 0; i < 8; i++)
        pack_byte(len[63 - 8 * i -: 8]);
      for (int i = 0; i < 5; i++) begin
        word.digest_word = hash_chain[i];
        word.word_index = i[2:0];
        word.last_word = (i[2:0] == LAST_WORD);
        digest_queue.push_back(word);
      end
      hash_reset();
    end
  endtask

  task automatic queue_message(int len, fill_style_t style, bit hold);
    queued_byte_t qb;
    for (int i = 0; i < len; i++) begin
      case (style)
        FILL_ONES:  qb.item.data_byte = 8'hFF;
        FILL_ZEROS: qb.item.data_byte = 8'h00;
        FILL_ALT:   qb.item.data_byte = i[0] ? 8'h00 : 8'hFF;
        default:    qb.item.data_byte = 8'($urandom);
      endcase
      qb.item.last_byte = (i == len - 1);
      qb.drain_first = hold && (i == 0);
      byte_queue.push_back(qb);
    end
  endtask

  // -------------------------------------------------------------------------
  // Input driver: predicts on every accepted byte, then waits a drawn gap.
  // A byte flagged drain_first is held back until no digest word is owed.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    queued_byte_t nxt;
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        hash_take_byte(in_data);
        in_idle_left = draw_wait(in_calm);
      end
      if (!in_valid || fire) begin
        if (in_idle_left > 0) begin
          in_idle_left--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain_first && digest_queue.size() != 0)) begin
          nxt = byte_queue.pop_front();
          in_data <= nxt.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output monitor: checks each accepted digest word against the oldest
  // expectation, then stalls for a drawn number of cycles.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    sha1_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          flag_error($sformatf("digest word %h index %0d with none expected",
                               out_data.digest_word, out_data.word_index));
        end else begin
          want = digest_queue.pop_front();
          if (out_data.digest_word !== want.digest_word)
            flag_error($sformatf("digest_word %h, expected %h (index %0d)",
                                 out_data.digest_word, want.digest_word, want.word_index));
          if (out_data.word_index !== want.word_index)
            flag_error($sformatf("word_index %0d, expected %0d",
                                 out_data.word_index, want.word_index));
          if (out_data.last_word !== want.last_word)
            flag_error($sformatf("last_word %b, expected %b (index %0d)",
                                 out_data.last_word, want.last_word, want.word_index));
        end
        out_idle_left = draw_wait(out_calm);
      end
      if (out_idle_left > 0) begin
        out_idle_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long quiet stretch means the block is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin
    int rand_items;
    int rand_msgs;
    int len;
    fill_style_t style;
    hash_reset();

    // directed: single-byte messages at both byte extremes, "abc",
    // then an alternating 0xFF/0x00 message
    queue_message(1, FILL_ZEROS, 1'b0);
    queue_message(1, FILL_ONES, 1'b0);
    begin
      queued_byte_t qb;
      qb.drain_first = 1'b0;
      qb.item = '{data_byte: 8'h61, last_byte: 1'b0};
      byte_queue.push_back(qb);
      qb.item = '{data_byte: 8'h62, last_byte: 1'b0};
      byte_queue.push_back(qb);
      qb.item = '{data_byte: 8'h63, last_byte: 1'b1};
      byte_queue.push_back(qb);
    end
    queue_message(20, FILL_ALT, 1'b0);

    // random: lengths lean on the padding boundaries (55/56 spill, 64 exact
    // block) and on tiny messages; a few run past two blocks
    rand_items = 0;
    rand_msgs = 0;
    while (rand_items < 225) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = $urandom_range(1, 4);
        3, 4, 5: len = $urandom_range(52, 68);
        6:       len = $urandom_range(117, 130);
        default: len = $urandom_range(1, 140);
      endcase
      case ($urandom_range(0, 7))
        0:       style = FILL_ONES;
        1:       style = FILL_ZEROS;
        default: style = FILL_RANDOM;
      endcase
      // first random message always waits for the directed digests to drain
      queue_message(len, style, rand_msgs == 0 || $urandom_range(0, 5) == 0);
      rand_items += len;
      rand_msgs++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || digest_queue.size() != 0);
    // catch any stray words after the last digest
    repeat (50) @(posedge clk);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
